FILE: rtl/core/kms_pkg.sv
package kms_pkg;

  // table geometry
  localparam int NUM_STACKS = 8;
  localparam int MAX_DEPTH  = 256;

  localparam int SLOT_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DEPTH_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int COUNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = SLOT_W + DEPTH_W;
  localparam int MEM_WORDS = NUM_STACKS << DEPTH_W;

  // field widths
  localparam int MODE_W     = 2;
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 9;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // operation codes
  localparam logic [MODE_W-1:0] OP_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [MODE_W-1:0] OP_POP    = 2'd2;
  localparam logic [MODE_W-1:0] OP_REMOVE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOKEY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

  // one classified command
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
    logic [COUNT_W-1:0] cap;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

FILE: rtl/core/kms_front.sv
module kms_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kms_pkg::MODE_W-1:0]    in_mode,
  input  logic [kms_pkg::KEY_W-1:0]     in_key,
  input  logic [kms_pkg::DATA_W-1:0]    in_value,
  input  logic [kms_pkg::CAP_W-1:0]     in_cap,
  output kms_pkg::head_t                head,
  input  logic                          take
);

  kms_pkg::cmd_t                  queue [kms_pkg::QUEUE_DEPTH];
  kms_pkg::cmd_t                  cmd_in;
  logic [kms_pkg::QPTR_W-1:0]     wr_ptr;
  logic [kms_pkg::QPTR_W-1:0]     rd_ptr;
  logic [kms_pkg::QCNT_W-1:0]     fill;
  logic                           push;
  logic                           pop;

  // capacity saturated to the per-slot depth
  always_comb begin
    cmd_in.mode  = in_mode;
    cmd_in.key   = in_key;
    cmd_in.value = in_value;
    if (32'(in_cap) > 32'(kms_pkg::MAX_DEPTH)) begin
      cmd_in.cap = kms_pkg::COUNT_W'(kms_pkg::MAX_DEPTH);
    end else begin
      cmd_in.cap = kms_pkg::COUNT_W'(in_cap);
    end
  end

  assign in_ready = (fill != kms_pkg::QCNT_W'(kms_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = take && (fill != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head.valid = (fill != '0);
  assign head.cmd   = queue[rd_ptr];

endmodule

FILE: rtl/core/kms_back.sv
module kms_back (
  input  logic                            clk,
  input  logic                            rst,
  input  kms_pkg::head_t                  head,
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kms_pkg::STATUS_W-1:0]    out_status,
  output logic [kms_pkg::DATA_W-1:0]      out_value,
  output logic [kms_pkg::OUT_SLOT_W-1:0]  out_slot
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                          state;
  logic                          slot_valid [kms_pkg::NUM_STACKS];
  logic [kms_pkg::KEY_W-1:0]     slot_key   [kms_pkg::NUM_STACKS];
  logic [kms_pkg::COUNT_W-1:0]   slot_cap   [kms_pkg::NUM_STACKS];
  logic [kms_pkg::COUNT_W-1:0]   slot_count [kms_pkg::NUM_STACKS];
  logic [kms_pkg::DATA_W-1:0]    mem        [kms_pkg::MEM_WORDS];
  logic [kms_pkg::DATA_W-1:0]    rdata;

  logic                          issue;
  logic                          found;
  logic                          has_free;
  logic [kms_pkg::SLOT_W-1:0]    hit_idx;
  logic [kms_pkg::SLOT_W-1:0]    free_idx;
  logic [kms_pkg::SLOT_W-1:0]    sel_idx;
  logic [kms_pkg::COUNT_W-1:0]   sel_count;
  logic [kms_pkg::COUNT_W-1:0]   pop_count;
  logic [kms_pkg::STATUS_W-1:0]  status;
  logic                          create_ok;
  logic                          push_ok;
  logic                          pop_ok;
  logic                          remove_ok;
  logic [kms_pkg::ADDR_W-1:0]    addr;

  assign issue = (state == ST_IDLE) && head.valid && (!out_valid || out_ready);
  assign take  = issue;

  // key match and first free slot, lowest index wins
  always_comb begin
    found    = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = kms_pkg::NUM_STACKS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_key[i] == head.cmd.key)) begin
        found   = 1'b1;
        hit_idx = kms_pkg::SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        has_free = 1'b1;
        free_idx = kms_pkg::SLOT_W'(i);
      end
    end
  end

  assign sel_count = slot_count[hit_idx];
  assign pop_count = sel_count - 1'b1;

  // operation decision
  always_comb begin
    status    = kms_pkg::ST_OK;
    sel_idx   = hit_idx;
    create_ok = 1'b0;
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    remove_ok = 1'b0;
    case (head.cmd.mode)
      kms_pkg::OP_CREATE: begin
        if (found) begin
          status = kms_pkg::ST_EXISTS;
        end else if (!has_free) begin
          status  = kms_pkg::ST_TABLE_FULL;
          sel_idx = '0;
        end else begin
          create_ok = 1'b1;
          sel_idx   = free_idx;
        end
      end
      kms_pkg::OP_PUSH: begin
        if (!found) begin
          status = kms_pkg::ST_NOKEY;
        end else if ((sel_count >= slot_cap[hit_idx]) ||
                     (sel_count >= kms_pkg::COUNT_W'(kms_pkg::MAX_DEPTH))) begin
          status = kms_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      kms_pkg::OP_POP: begin
        if (!found) begin
          status = kms_pkg::ST_NOKEY;
        end else if ((sel_count == '0) ||
                     (sel_count > kms_pkg::COUNT_W'(kms_pkg::MAX_DEPTH))) begin
          status = kms_pkg::ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: begin
        if (!found) begin
          status = kms_pkg::ST_NOKEY;
        end else begin
          remove_ok = 1'b1;
        end
      end
    endcase
  end

  // element address: slot base plus stack index
  always_comb begin
    if (pop_ok) begin
      addr = {hit_idx, pop_count[kms_pkg::DEPTH_W-1:0]};
    end else begin
      addr = {hit_idx, sel_count[kms_pkg::DEPTH_W-1:0]};
    end
  end

  // element memory, one port
  always_ff @(posedge clk) begin
    if (issue && push_ok) begin
      mem[addr] <= head.cmd.value;
    end
    if (issue && pop_ok) begin
      rdata <= mem[addr];
    end
  end

  // descriptor table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kms_pkg::NUM_STACKS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_key[i]   <= '0;
        slot_cap[i]   <= '0;
        slot_count[i] <= '0;
      end
    end else if (issue) begin
      if (create_ok) begin
        slot_valid[sel_idx] <= 1'b1;
        slot_key[sel_idx]   <= head.cmd.key;
        slot_cap[sel_idx]   <= head.cmd.cap;
        slot_count[sel_idx] <= '0;
      end
      if (push_ok) begin
        slot_count[hit_idx] <= sel_count + 1'b1;
      end
      if (pop_ok) begin
        slot_count[hit_idx] <= pop_count;
      end
      if (remove_ok) begin
        slot_valid[hit_idx] <= 1'b0;
        slot_key[hit_idx]   <= '0;
        slot_cap[hit_idx]   <= '0;
        slot_count[hit_idx] <= '0;
      end
    end
  end

  // sequencer: a successful pop waits in the read state for the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (issue && pop_ok) begin
      state <= ST_READ;
    end else begin
      state <= ST_IDLE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= !pop_ok;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_status <= status;
      out_value  <= '0;
      out_slot   <= kms_pkg::OUT_SLOT_W'(sel_idx);
    end else if (state == ST_READ) begin
      out_value <= rdata;
    end
  end

  // checks
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid)
    else $error("pop read started while result register busy");

  a_read_gives_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid && out_status == kms_pkg::ST_OK)
    else $error("pop read did not deliver an ok result");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != kms_pkg::ST_OK |-> out_value == '0)
    else $error("nonzero value on a failed result");

  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    issue && push_ok |-> sel_count < kms_pkg::COUNT_W'(kms_pkg::MAX_DEPTH))
    else $error("push beyond slot depth");

  a_create_unique: assert property (@(posedge clk) disable iff (rst)
    issue && create_ok |-> !found && !slot_valid[free_idx])
    else $error("create claimed a slot in use");

endmodule

FILE: rtl/core/keyed_multi_stack_engine.sv
// keyed multi-stack engine: eight stacks of up to 256 words, each named by
// a 32-bit key, driven by one command beat per operation.
// input channel s_*: s_tuser carries the operation (create, push, pop,
// remove), s_tdata the key, the pushed value and the create capacity.
// output channel m_*: one result beat per command, in command order, with
// status, popped value and slot number in m_tdata.
// commands enter a two-entry queue, so the input keeps accepting while the
// executing side is busy or the output is stalled.
// a create, push or remove result is registered from the queue head at
// issue; a successful pop result waits for the registered memory read.
// throughput: one command per cycle unless m_tready stalls; a successful
// pop holds off the next command while its element is read from memory.
// lookup compares the key against all descriptors in the cycle of issue.
// reset clears every descriptor and the queue; element memory is not
// cleared, since a stack only reads words it has pushed.
// when m_tready is low the result is held and, once the queue is full,
// s_tready drops until the result is taken.
module keyed_multi_stack_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // stack_key[31:0], push_value[63:32], capacity[72:64]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[2:0], pop_value[34:3], slot[37:35]
);

  kms_pkg::head_t                       head;
  logic                                 take;
  logic [kms_pkg::STATUS_W-1:0]         out_status;
  logic [kms_pkg::DATA_W-1:0]           out_value;
  logic [kms_pkg::OUT_SLOT_W-1:0]       out_slot;

  kms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_key   (s_tdata[31:0]),
    .in_value (s_tdata[63:32]),
    .in_cap   (s_tdata[72:64]),
    .head     (head),
    .take     (take)
  );

  kms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_slot   (out_slot)
  );

  // result packing
  assign m_tdata = {2'b00, out_slot, out_value, out_status};

endmodule

FILE: bench/tb_keyed_multi_stack_engine.sv
`default_nettype none

module tb_keyed_multi_stack_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // one result beat as the block should deliver it
  typedef struct packed {
    logic [kms_pkg::STATUS_W-1:0]   status;
    logic [kms_pkg::DATA_W-1:0]     pop_value;
    logic [kms_pkg::OUT_SLOT_W-1:0] slot;
  } stack_result_t;

  // keeps its own copy of the descriptor table and element words,
  // predicts each result and checks the beats in order
  class stack_result_board;
    bit                         in_use      [kms_pkg::NUM_STACKS];
    logic [kms_pkg::KEY_W-1:0]  owner_key   [kms_pkg::NUM_STACKS];
    int                         depth_limit [kms_pkg::NUM_STACKS];
    int                         fill        [kms_pkg::NUM_STACKS];
    logic [kms_pkg::DATA_W-1:0] words       [kms_pkg::NUM_STACKS*kms_pkg::MAX_DEPTH];
    stack_result_t              awaited_results[$];
    int                         mismatches;
    int                         op_count     [4];
    int                         status_count [8];

    function new();
      for (int s = 0; s < kms_pkg::NUM_STACKS; s++) begin
        in_use[s]      = 1'b0;
        owner_key[s]   = '0;
        depth_limit[s] = 0;
        fill[s]        = 0;
      end
      mismatches = 0;
      for (int i = 0; i < 4; i++) op_count[i] = 0;
      for (int i = 0; i < 8; i++) status_count[i] = 0;
    endfunction

    function int find_owner(logic [kms_pkg::KEY_W-1:0] key);
      for (int s = 0; s < kms_pkg::NUM_STACKS; s++) begin
        if (in_use[s] && owner_key[s] == key) return s;
      end
      return -1;
    endfunction

    function int free_slots();
      int n;
      n = 0;
      for (int s = 0; s < kms_pkg::NUM_STACKS; s++) begin
        if (!in_use[s]) n++;
      end
      return n;
    endfunction

    // next state of the table and the result that one command yields
    function stack_result_t predict_stack_op(logic [kms_pkg::MODE_W-1:0] op,
                                             logic [kms_pkg::KEY_W-1:0] key,
                                             logic [kms_pkg::DATA_W-1:0] value,
                                             logic [kms_pkg::CAP_W-1:0] cap);
      stack_result_t r;
      int hit;
      int spare;
      r.status    = kms_pkg::ST_OK;
      r.pop_value = '0;
      r.slot      = '0;
      hit = find_owner(key);
      if (op == kms_pkg::OP_CREATE) begin
        if (hit >= 0) begin
          r.status = kms_pkg::ST_EXISTS;
          r.slot   = hit[kms_pkg::OUT_SLOT_W-1:0];
        end else begin
          spare = -1;
          for (int s = kms_pkg::NUM_STACKS - 1; s >= 0; s--) begin
            if (!in_use[s]) spare = s;
          end
          if (spare < 0) begin
            r.status = kms_pkg::ST_TABLE_FULL;
          end else begin
            in_use[spare]      = 1'b1;
            owner_key[spare]   = key;
            depth_limit[spare] = (int'(cap) > kms_pkg::MAX_DEPTH) ? kms_pkg::MAX_DEPTH
                                                                   : int'(cap);
            fill[spare]        = 0;
            r.slot             = spare[kms_pkg::OUT_SLOT_W-1:0];
          end
        end
      end else if (hit < 0) begin
        r.status = kms_pkg::ST_NOKEY;
      end else begin
        r.slot = hit[kms_pkg::OUT_SLOT_W-1:0];
        case (op)
          kms_pkg::OP_PUSH: begin
            if (fill[hit] >= depth_limit[hit]) begin
              r.status = kms_pkg::ST_FULL;
            end else begin
              words[hit*kms_pkg::MAX_DEPTH + fill[hit]] = value;
              fill[hit]++;
            end
          end
          kms_pkg::OP_POP: begin
            if (fill[hit] == 0) begin
              r.status = kms_pkg::ST_EMPTY;
            end else begin
              fill[hit]--;
              r.pop_value = words[hit*kms_pkg::MAX_DEPTH + fill[hit]];
            end
          end
          default: begin
            // remove keeps the element words
            in_use[hit]      = 1'b0;
            owner_key[hit]   = '0;
            depth_limit[hit] = 0;
            fill[hit]        = 0;
          end
        endcase
      end
      return r;
    endfunction

    function void note_command(logic [kms_pkg::MODE_W-1:0] op,
                               logic [kms_pkg::KEY_W-1:0] key,
                               logic [kms_pkg::DATA_W-1:0] value,
                               logic [kms_pkg::CAP_W-1:0] cap);
      stack_result_t r;
      r = predict_stack_op(op, key, value, cap);
      op_count[op]++;
      status_count[r.status]++;
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [39:0] beat);
      stack_result_t want;
      stack_result_t got;
      got.status    = beat[2:0];
      got.pop_value = beat[34:3];
      got.slot      = beat[37:35];
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing awaited: status %0d pop_value %h slot %0d",
                 $time, got.status, got.pop_value, got.slot);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.pop_value !== want.pop_value) begin
        mismatches++;
        $display("%0t: pop_value expected %h actual %h", $time, want.pop_value, got.pop_value);
      end
      if (got.slot !== want.slot) begin
        mismatches++;
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // stack_key[31:0], push_value[63:32], capacity[72:64]
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status[2:0], pop_value[34:3], slot[37:35]

  stack_result_board         board;
  bit                        no_idle;
  int                        random_items;
  logic [kms_pkg::KEY_W-1:0] key_pool [12];

  keyed_multi_stack_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // send one command beat; called and returns just after a falling edge
  task automatic issue_command(logic [kms_pkg::MODE_W-1:0] op,
                               logic [kms_pkg::KEY_W-1:0] key,
                               logic [kms_pkg::DATA_W-1:0] value,
                               logic [kms_pkg::CAP_W-1:0] cap);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {7'd0, cap, value, key};
    do @(posedge clk); while (!s_tready);
    board.note_command(op, key, value, cap);
    @(negedge clk);
  endtask

  function automatic logic [kms_pkg::CAP_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 80) return kms_pkg::CAP_W'($urandom_range(12, 1));
    if (r < 95) return kms_pkg::CAP_W'($urandom_range(300, 13));
    return kms_pkg::CAP_W'($urandom_range(511, 0));
  endfunction

  function automatic logic [kms_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 20) return kms_pkg::OP_CREATE;
    if (r < 55) return kms_pkg::OP_PUSH;
    if (r < 85) return kms_pkg::OP_POP;
    return kms_pkg::OP_REMOVE;
  endfunction

  // random command from the key pool, counted toward the random part
  task automatic pool_command(logic [kms_pkg::MODE_W-1:0] op,
                              logic [kms_pkg::KEY_W-1:0] key);
    issue_command(op, key, $urandom, pick_capacity());
    random_items++;
    no_idle = (random_items >= 60 && random_items < 170);
  endtask

  // create a stack with a capacity past the table depth and push it past full
  task automatic saturated_fill();
    logic [kms_pkg::KEY_W-1:0] key;
    int k;
    key = key_pool[0];
    k = 1;
    pool_command(kms_pkg::OP_REMOVE, key);
    while (board.free_slots() == 0 && k < 12) begin
      pool_command(kms_pkg::OP_REMOVE, key_pool[k]);
      k++;
    end
    issue_command(kms_pkg::OP_CREATE, key, $urandom,
                  kms_pkg::CAP_W'($urandom_range(511, kms_pkg::MAX_DEPTH + 1)));
    random_items++;
    for (int i = 0; i <= kms_pkg::MAX_DEPTH; i++) pool_command(kms_pkg::OP_PUSH, key);
    for (int i = 0; i < 6; i++) pool_command(kms_pkg::OP_POP, key);
    pool_command(kms_pkg::OP_REMOVE, key);
  endtask

  // drive the result side: ready drops about 29 times in 100, except while no_idle holds it high
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = !rst && (no_idle || $urandom_range(99) >= 29);
    end
  end

  // check each result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_keyed_multi_stack_engine: done, errors");
    $finish;
  end

  initial begin
    logic [kms_pkg::KEY_W-1:0]  key;
    logic [kms_pkg::MODE_W-1:0] mode;
    int                         seq;
    int                         n;
    bit                         filled;
    board    = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = kms_pkg::OP_CREATE;
    no_idle  = 1'b0;
    filled   = 1'b0;
    random_items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: key extremes, zero capacity, saturation, every status
    issue_command(kms_pkg::OP_POP,    32'h0000_0000, 32'h0,         9'd4);
    issue_command(kms_pkg::OP_CREATE, 32'h0000_0000, 32'h0,         9'd0);
    issue_command(kms_pkg::OP_PUSH,   32'h0000_0000, 32'h1234_5678, 9'd0);
    issue_command(kms_pkg::OP_POP,    32'h0000_0000, 32'h0,         9'd0);
    issue_command(kms_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);
    issue_command(kms_pkg::OP_PUSH,   32'hFFFF_FFFF, 32'h8000_0000, 9'd0);
    issue_command(kms_pkg::OP_PUSH,   32'hFFFF_FFFF, 32'h7FFF_FFFF, 9'd0);
    issue_command(kms_pkg::OP_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
    for (int i = 0; i < 4; i++) begin
      issue_command(kms_pkg::OP_POP, 32'hFFFF_FFFF, 32'h0, 9'd0);
    end
    issue_command(kms_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'h0,         9'd5);
    issue_command(kms_pkg::OP_CREATE, 32'hA5A5_A5A5, 32'h0,         9'd1);
    issue_command(kms_pkg::OP_PUSH,   32'hA5A5_A5A5, 32'h0000_0001, 9'd0);
    issue_command(kms_pkg::OP_PUSH,   32'hA5A5_A5A5, 32'h0000_0002, 9'd0);
    issue_command(kms_pkg::OP_CREATE, 32'h5A5A_5A5A, 32'h0,         9'd256);
    for (int i = 1; i <= 4; i++) begin
      issue_command(kms_pkg::OP_CREATE, kms_pkg::KEY_W'(i), 32'h0, 9'd3);
    end
    issue_command(kms_pkg::OP_CREATE, 32'h1234_5678, 32'h0,         9'd2);
    issue_command(kms_pkg::OP_REMOVE, 32'h0000_0000, 32'h0,         9'd0);
    issue_command(kms_pkg::OP_REMOVE, 32'h0000_0000, 32'h0,         9'd0);
    issue_command(kms_pkg::OP_PUSH,   32'h0BAD_F00D, 32'h5555_5555, 9'd0);
    issue_command(kms_pkg::OP_CREATE, 32'h1234_5678, 32'h0,         9'd2);

    // directed keys seed the pool so random removes can free the table
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'hA5A5_A5A5;
    key_pool[2] = 32'h5A5A_5A5A;
    key_pool[3] = 32'h0000_0001;
    key_pool[4] = 32'h0000_0002;
    key_pool[5] = 32'h0000_0003;
    key_pool[6] = 32'h0000_0004;
    key_pool[7] = 32'h1234_5678;
    for (int i = 8; i < 12; i++) key_pool[i] = $urandom;

    // random: well-formed create/push/pop runs, single ops and noise
    while (random_items < 500) begin
      if (!filled && random_items >= 250) begin
        saturated_fill();
        filled = 1'b1;
      end
      seq = $urandom_range(99);
      key = key_pool[$urandom_range(11)];
      if (seq < 40) begin
        pool_command(kms_pkg::OP_CREATE, key);
        n = $urandom_range(14);
        for (int i = 0; i < n; i++) pool_command(kms_pkg::OP_PUSH, key);
        n = $urandom_range(n + 2);
        for (int i = 0; i < n; i++) pool_command(kms_pkg::OP_POP, key);
        if ($urandom_range(1)) pool_command(kms_pkg::OP_REMOVE, key);
      end else if (seq < 80) begin
        pool_command(pick_mode(), key);
      end else begin
        // noise: fresh key, which joins the pool when it is created
        key = $urandom;
        n = $urandom_range(11);
        if ($urandom_range(1) && board.find_owner(key_pool[n]) < 0) begin
          key_pool[n] = key;
          pool_command(kms_pkg::OP_CREATE, key);
        end else begin
          // a fresh key outside the pool is never created
          mode = pick_mode();
          if (mode == kms_pkg::OP_CREATE) mode = kms_pkg::OP_REMOVE;
          pool_command(mode, key);
        end
      end
    end
    s_tvalid = 1'b0;

    // drain
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d create, %0d push, %0d pop, %0d remove commands",
             board.op_count[kms_pkg::OP_CREATE], board.op_count[kms_pkg::OP_PUSH],
             board.op_count[kms_pkg::OP_POP], board.op_count[kms_pkg::OP_REMOVE]);
    $display("statuses: ok %0d, exists %0d, no key %0d, full %0d, empty %0d, table full %0d",
             board.status_count[kms_pkg::ST_OK], board.status_count[kms_pkg::ST_EXISTS],
             board.status_count[kms_pkg::ST_NOKEY], board.status_count[kms_pkg::ST_FULL],
             board.status_count[kms_pkg::ST_EMPTY],
             board.status_count[kms_pkg::ST_TABLE_FULL]);
    if (board.mismatches == 0) begin
      $display("tb_keyed_multi_stack_engine: done, clean");
    end else begin
      $display("tb_keyed_multi_stack_engine: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/kms_pkg.sv
rtl/core/kms_front.sv
rtl/core/kms_back.sv
rtl/core/keyed_multi_stack_engine.sv
bench/tb_keyed_multi_stack_engine.sv
